// ===== hdl/cpjq_pkg.sv =====
// ============================================================================
// Class priority job queue - shared definitions
// Default sizes, class and operation codes and the result flag word used by
// the queue sequencer and its ordering compare unit.
// ============================================================================
package cpjq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 64;
    localparam int DEFAULT_PAGE_BITS   = 16;

    // Widths of the fields on the stream ports.
    localparam int CLASS_W    = 2;
    localparam int IN_PAGES_W = 16;

    // Job classes, served in ascending code order.
    localparam logic [CLASS_W-1:0] CLASS_P = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_S = 2'd2;

    // Request kinds carried on the input tuser.
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // Status flags of one result, out_valid in the lowest bit.
    typedef struct packed {
        logic now_empty;
        logic dropped_full;
        logic was_empty;
        logic out_valid;
    } result_flags_t;

endpackage

// ===== hdl/cpjq_store.sv =====
// ============================================================================
// Class priority job queue - job store
// Single-port-write, single-port-read memory with a registered read, holding
// one job (class and pages) per entry in queue order.
// ============================================================================
module cpjq_store #(
    parameter  int DEPTH = cpjq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter  int WIDTH = cpjq_pkg::DEFAULT_PAGE_BITS + cpjq_pkg::CLASS_W,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A read is taken every cycle; the sequencer only uses the words it asked for.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/cpjq_order_cmp.sv =====
// ============================================================================
// Class priority job queue - ordering compare unit
// Decides whether a queued job stays ahead of the job being inserted: lower
// class first, then strictly fewer pages.
// ============================================================================
module cpjq_order_cmp #(
    parameter int PAGE_BITS = cpjq_pkg::DEFAULT_PAGE_BITS
) (
    input  logic [cpjq_pkg::CLASS_W-1:0] entry_class,
    input  logic [PAGE_BITS-1:0]         entry_pages,
    input  logic [cpjq_pkg::CLASS_W-1:0] new_class,
    input  logic [PAGE_BITS-1:0]         new_pages,
    output logic                         keep_ahead
);

    import cpjq_pkg::*;

    // Equal pages do not keep the queued job ahead, so a new job overtakes them.
    assign keep_ahead = (entry_class < new_class) ||
                        ((entry_class == new_class) && (entry_pages < new_pages));

endmodule

// ===== hdl/class_priority_job_queue.sv =====
// ============================================================================
// Class priority job queue
// Ordered print-job queue with three classes, sorted insert and head removal,
// built around one job memory walked by a small sequencer.
// ============================================================================
// The queue holds up to QUEUE_DEPTH jobs in one ordered list: class P before
// A before S, and within a class by ascending page count, a new job going
// ahead of queued jobs of its class with the same page count. Each request
// word returns exactly one result word. The block takes one request at a
// time and drops s_tready while it works on it. All jobs sit in a single
// memory with one write and one registered read port, and that port sets
// the timing. An enqueue walks from the tail towards the head, moving one
// job back per cycle until it finds its place; a dequeue reads the head and
// then moves every remaining job forward by one. A request that causes no
// walk (an empty dequeue, a full or invalid enqueue, or an enqueue into an
// empty queue) goes straight to its result. A finished result that has to
// wait behind an unaccepted word in the output register holds up the next
// request. The memory needs no clearing after reset, since only entries
// below the job count are ever used. A finished result waits in the output
// register while the next request is taken.
module class_priority_job_queue #(
    parameter int QUEUE_DEPTH = cpjq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int PAGE_BITS   = cpjq_pkg::DEFAULT_PAGE_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [1:0] user_class, [17:2] pages, [23:18] zero
    input  logic [0:0]  s_tuser,   // [0] operation
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] out_pages, [17:16] out_class, [23:18] zero
    output logic [3:0]  m_tuser    // [0] out_valid, [1] was_empty, [2] dropped_full,
                                   // [3] now_empty
);

    import cpjq_pkg::*;

    localparam int AW      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = PAGE_BITS + CLASS_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_ENQ_WALK  = 6'b000010,
        ST_ENQ_PUT   = 6'b000100,
        ST_DEQ_HEAD  = 6'b001000,
        ST_DEQ_SHIFT = 6'b010000,
        ST_RESP      = 6'b100000
    } state_t;

    // Request fields.
    logic                  in_op;
    logic [CLASS_W-1:0]    in_class;
    logic [IN_PAGES_W-1:0] in_pages;

    assign in_op    = s_tuser[0];
    assign in_class = s_tdata[1:0];
    assign in_pages = s_tdata[17:2];

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [AW-1:0]         k_reg, k_next;
    logic [PAGE_BITS-1:0]  new_pages_reg, new_pages_next;
    logic [CLASS_W-1:0]    new_class_reg, new_class_next;
    logic [PAGE_BITS-1:0]  res_pages_reg, res_pages_next;
    logic [CLASS_W-1:0]    res_class_reg, res_class_next;
    result_flags_t         res_flags_reg, res_flags_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [IN_PAGES_W-1:0] m_pages_reg, m_pages_next;
    logic [CLASS_W-1:0]    m_class_reg, m_class_next;
    result_flags_t         m_flags_reg, m_flags_next;

    // Memory and compare unit connections.
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [ENTRY_W-1:0]    wr_data;
    logic [AW-1:0]         rd_addr;
    logic [ENTRY_W-1:0]    rd_data;
    logic                  keep_ahead;

    cpjq_store #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cpjq_order_cmp #(
        .PAGE_BITS (PAGE_BITS)
    ) u_cmp (
        .entry_class (rd_data[ENTRY_W-1:PAGE_BITS]),
        .entry_pages (rd_data[PAGE_BITS-1:0]),
        .new_class   (new_class_reg),
        .new_pages   (new_pages_reg),
        .keep_ahead  (keep_ahead)
    );

    assign s_tready = (state_reg == ST_IDLE);

    // Sequencer. Reads are issued in the cycle before their data is used, so in every walking
    // state the read data belongs to the entry next to the one being written.
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        k_next         = k_reg;
        new_pages_next = new_pages_reg;
        new_class_next = new_class_reg;
        res_pages_next = res_pages_reg;
        res_class_next = res_class_reg;
        res_flags_next = res_flags_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_pages_next   = m_pages_reg;
        m_class_next   = m_class_reg;
        m_flags_next   = m_flags_reg;
        wr_en          = 1'b0;
        wr_addr        = k_reg;
        wr_data        = {new_class_reg, new_pages_reg};
        rd_addr        = k_reg - AW'(2);

        case (state_reg)
            ST_IDLE: begin
                // Tail for an enqueue walk, head for a dequeue.
                rd_addr = (in_op == OP_DEQUEUE) ? '0 : AW'(count_reg - CNT_W'(1));
                if (s_tvalid) begin
                    new_pages_next = PAGE_BITS'(in_pages);
                    new_class_next = in_class;
                    res_pages_next = '0;
                    res_class_next = CLASS_P;
                    res_flags_next = '0;
                    if (in_op == OP_ENQUEUE) begin
                        if (in_class > CLASS_S) begin
                            // Unknown class: nothing is queued and only now_empty can be raised.
                            state_next = ST_RESP;
                        end else if (count_reg == FULL_COUNT) begin
                            res_flags_next.dropped_full = 1'b1;
                            state_next = ST_RESP;
                        end else if (count_reg == '0) begin
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            wr_data    = {in_class, PAGE_BITS'(in_pages)};
                            count_next = count_reg + CNT_W'(1);
                            state_next = ST_RESP;
                        end else begin
                            k_next     = AW'(count_reg);
                            state_next = ST_ENQ_WALK;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            res_flags_next.was_empty = 1'b1;
                            state_next = ST_RESP;
                        end else begin
                            state_next = ST_DEQ_HEAD;
                        end
                    end
                end
            end

            ST_ENQ_WALK: begin
                // rd_data holds entry k-1; either it stays ahead and the new
                // job lands at k, or it moves back into k.
                if (keep_ahead) begin
                    wr_en      = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_RESP;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = rd_data;
                    k_next  = k_reg - AW'(1);
                    if (k_reg == AW'(1)) begin
                        state_next = ST_ENQ_PUT;
                    end
                end
            end

            ST_ENQ_PUT: begin
                // Every queued job went behind the new one: it becomes the head.
                wr_en      = 1'b1;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_RESP;
            end

            ST_DEQ_HEAD: begin
                res_pages_next           = rd_data[PAGE_BITS-1:0];
                res_class_next           = rd_data[ENTRY_W-1:PAGE_BITS];
                res_flags_next.out_valid = 1'b1;
                rd_addr                  = AW'(1);
                k_next                   = AW'(1);
                if (count_reg == CNT_W'(1)) begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_RESP;
                end else begin
                    state_next = ST_DEQ_SHIFT;
                end
            end

            ST_DEQ_SHIFT: begin
                // rd_data holds entry k, which moves forward into k-1.
                wr_en   = 1'b1;
                wr_addr = k_reg - AW'(1);
                wr_data = rd_data;
                rd_addr = k_reg + AW'(1);
                if (CNT_W'(k_reg) == count_reg - CNT_W'(1)) begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = ST_RESP;
                end else begin
                    k_next = k_reg + AW'(1);
                end
            end

            ST_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next          = 1'b1;
                    m_pages_next           = IN_PAGES_W'(res_pages_reg);
                    m_class_next           = res_class_reg;
                    m_flags_next           = res_flags_reg;
                    m_flags_next.now_empty = (count_reg == '0);
                    state_next             = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg         <= k_next;
        new_pages_reg <= new_pages_next;
        new_class_reg <= new_class_next;
        res_pages_reg <= res_pages_next;
        res_class_reg <= res_class_next;
        res_flags_reg <= res_flags_next;
        m_pages_reg   <= m_pages_next;
        m_class_reg   <= m_class_next;
        m_flags_reg   <= m_flags_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_class_reg, m_pages_reg};
    assign m_tuser  = m_flags_reg;

    // The job count never passes the store depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
    else $error("job count beyond store depth");

    // The job count moves by at most one job per cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == $past(count_reg)) ||
        (count_reg == CNT_W'($past(count_reg) + CNT_W'(1))) ||
        (count_reg == CNT_W'($past(count_reg) - CNT_W'(1))))
    else $error("job count jumped");

    // An enqueue walk only writes between entry 1 and the first free entry of the store.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ENQ_WALK) |-> ((k_reg != '0) && (CNT_W'(k_reg) <= count_reg)))
    else $error("enqueue walk outside the queued jobs");

    // A result never claims both a returned job and an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_flags_reg.out_valid && m_flags_reg.was_empty))
    else $error("result flags contradict each other");

    // A dequeue that returns a job leaves the count one lower.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DEQ_HEAD) |=> (res_flags_reg.out_valid &&
            (count_reg == CNT_W'($past(count_reg) - CNT_W'(1)) ||
             state_reg == ST_DEQ_SHIFT)))
    else $error("dequeue did not take the head job");

endmodule

// ===== bench/tb_class_priority_job_queue.sv =====
// ============================================================================
// Class priority job queue - testbench
// Drives enqueue and dequeue request words into the queue, predicts every
// result word from an independent model of the ordered job list and checks
// each one field by field, with random stalls on both channels in most tests.
// ============================================================================
module tb_class_priority_job_queue;

    import cpjq_pkg::*;

    // The package names only the P and S classes. The middle class and the
    // unused code, which the block must ignore, are given names here.
    localparam logic [CLASS_W-1:0] CLASS_A   = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_BAD = 2'd3;

    localparam int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH;
    // Receiver hold-off used to fill the block and stall its request side.
    localparam int HOLD_CYCLES = 400;
    // Cycles allowed after the last result, twice the queue depth and a margin.
    localparam int TAIL_CYCLES = 2 * QUEUE_DEPTH + 10;

    // One queued job as the model keeps it.
    typedef struct packed {
        logic [CLASS_W-1:0]    cls;
        logic [IN_PAGES_W-1:0] pages;
    } job_t;

    // One result word as expected on the output channel.
    typedef struct packed {
        logic [15:0]        pages;
        logic [CLASS_W-1:0] cls;
        result_flags_t      flags;
    } job_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [3:0]  m_tuser;

    // Model of the job list in queue order, and the result words still owed.
    job_t        pending_jobs[$];
    job_result_t expected_results[$];
    job_result_t head_result;

    int failure_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Set by a test to start one long hold-off; the receiver counts it down.
    logic hold_request = 1'b0;
    int   hold_left    = 0;

    class_priority_job_queue u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Safety net against a hung handshake; far above the slowest correct run.
    initial begin
        #10_000_000;
        $display("** class_priority_job_queue: FAILED **");
        $finish;
    end

    task automatic report_failure(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        failure_count++;
    endtask

    // Applies one request word to the model and returns the result word the
    // block owes for it. Jobs go ahead of the first queued job of a later
    // class, or of the first job of their own class with as many pages or
    // more, so a new job overtakes older jobs with equal pages.
    function automatic job_result_t predict_result(input logic op,
                                                   input logic [CLASS_W-1:0] cls,
                                                   input logic [IN_PAGES_W-1:0] pg);
        job_result_t res;
        job_t        job;
        int          pos;
        res = '0;
        if (op == OP_ENQUEUE) begin
            // The unused class code leaves the queue as it is.
            if (cls != CLASS_BAD) begin
                if (pending_jobs.size() >= QUEUE_DEPTH) begin
                    res.flags.dropped_full = 1'b1;
                end else begin
                    pos = 0;
                    while (pos < pending_jobs.size() &&
                           !(pending_jobs[pos].cls > cls ||
                             (pending_jobs[pos].cls == cls && pending_jobs[pos].pages >= pg)))
                        pos++;
                    job.cls   = cls;
                    job.pages = pg;
                    pending_jobs.insert(pos, job);
                end
            end
        end else if (pending_jobs.size() == 0) begin
            res.flags.was_empty = 1'b1;
        end else begin
            job = pending_jobs.pop_front();
            res.pages           = job.pages;
            res.cls             = job.cls;
            res.flags.out_valid = 1'b1;
        end
        res.flags.now_empty = (pending_jobs.size() == 0);
        return res;
    endfunction

    // Offers one request word and waits for it to be taken. The valid is
    // left high afterwards: the next call, a gap or a drain lowers it, so it
    // is never lowered and raised within one time step.
    task automatic send_word(input logic op, input logic [CLASS_W-1:0] cls,
                             input logic [IN_PAGES_W-1:0] pg);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, pg, cls};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        expected_results.push_back(predict_result(op, cls, pg));
    endtask

    // The sender stops and waits until every owed result word has arrived.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (expected_results.size() != 0);
    endtask

    // Page counts weighted towards the extremes and towards a few small
    // values, so that ties within a class are common.
    function automatic logic [IN_PAGES_W-1:0] pick_pages();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return IN_PAGES_W'($urandom_range(7));
            default: return IN_PAGES_W'($urandom);
        endcase
    endfunction

    // Receiver: random stalls, or one long hold-off when a test asks for it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Result checker: every taken result word is matched against the oldest
    // expectation. Values are read at the edge, before any update lands.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report_failure($sformatf("result word %h/%h with no request waiting",
                                         m_tdata, m_tuser));
            end else begin
                head_result = expected_results.pop_front();
                if (m_tdata[15:0] !== head_result.pages)
                    report_failure($sformatf("out_pages %h, expected %h",
                                             m_tdata[15:0], head_result.pages));
                if (m_tdata[17:16] !== head_result.cls)
                    report_failure($sformatf("out_class %h, expected %h",
                                             m_tdata[17:16], head_result.cls));
                if (m_tuser[0] !== head_result.flags.out_valid)
                    report_failure($sformatf("out_valid %b, expected %b",
                                             m_tuser[0], head_result.flags.out_valid));
                if (m_tuser[1] !== head_result.flags.was_empty)
                    report_failure($sformatf("was_empty %b, expected %b",
                                             m_tuser[1], head_result.flags.was_empty));
                if (m_tuser[2] !== head_result.flags.dropped_full)
                    report_failure($sformatf("dropped_full %b, expected %b",
                                             m_tuser[2], head_result.flags.dropped_full));
                if (m_tuser[3] !== head_result.flags.now_empty)
                    report_failure($sformatf("now_empty %b, expected %b",
                                             m_tuser[3], head_result.flags.now_empty));
            end
        end
    end

    // Dequeues on a queue that has never held a job.
    task automatic test_empty_dequeue();
        send_word(OP_DEQUEUE, CLASS_P, '0);
        send_word(OP_DEQUEUE, CLASS_BAD, '1);
        wait_drained();
    endtask

    // Page extremes in each class (both for P), and the unused class code, which must
    // be ignored even with the largest page count.
    task automatic test_page_extremes();
        send_word(OP_ENQUEUE, CLASS_S, '1);
        send_word(OP_ENQUEUE, CLASS_P, '1);
        send_word(OP_ENQUEUE, CLASS_A, '0);
        send_word(OP_ENQUEUE, CLASS_BAD, '1);
        send_word(OP_ENQUEUE, CLASS_P, '0);
        send_word(OP_ENQUEUE, CLASS_BAD, '0);
        repeat (5)
            send_word(OP_DEQUEUE, CLASS_P, '0);
        wait_drained();
    endtask

    // Class order ahead of page order, and a new job against queued jobs of
    // its class with the same page count.
    task automatic test_class_order();
        send_word(OP_ENQUEUE, CLASS_S, 16'd5);
        send_word(OP_ENQUEUE, CLASS_A, 16'd5);
        send_word(OP_ENQUEUE, CLASS_P, 16'd5);
        send_word(OP_ENQUEUE, CLASS_A, 16'd3);
        send_word(OP_ENQUEUE, CLASS_A, 16'd5);
        send_word(OP_ENQUEUE, CLASS_P, 16'd7);
        repeat (7)
            send_word(OP_DEQUEUE, CLASS_S, '1);
        wait_drained();
    endtask

    // Fills the store, tries to overfill it, frees one place and refills it,
    // then empties it again down to an empty dequeue.
    task automatic test_full_store();
        while (pending_jobs.size() < QUEUE_DEPTH)
            send_word(OP_ENQUEUE, CLASS_W'($urandom_range(2)), pick_pages());
        send_word(OP_ENQUEUE, CLASS_P, '0);
        send_word(OP_ENQUEUE, CLASS_S, '1);
        send_word(OP_ENQUEUE, CLASS_BAD, pick_pages());
        send_word(OP_DEQUEUE, CLASS_P, '0);
        send_word(OP_ENQUEUE, CLASS_P, '0);
        send_word(OP_ENQUEUE, CLASS_A, pick_pages());
        while (pending_jobs.size() > 0)
            send_word(OP_DEQUEUE, CLASS_P, '0);
        send_word(OP_DEQUEUE, CLASS_P, '0);
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering words, so that the block fills up and stalls its input.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        repeat (40) begin
            if ($urandom_range(99) < 75)
                send_word(OP_ENQUEUE, CLASS_W'($urandom_range(2)), pick_pages());
            else
                send_word(OP_DEQUEUE, CLASS_P, '0);
        end
        wait_drained();
    endtask

    // Random traffic in bursts that lean towards filling, draining or an even
    // mix, so the queue sweeps from empty to full. Ignored words are noise
    // and do not count towards the item total.
    task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct);
        int sent;
        int burst_len;
        int enq_pct;
        logic op;
        logic [CLASS_W-1:0] cls;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        while (sent < n_items) begin
            burst_len = $urandom_range(8, 80);
            case ($urandom_range(2))
                0:       enq_pct = 85;
                1:       enq_pct = 20;
                default: enq_pct = 50;
            endcase
            repeat (burst_len) begin
                op  = ($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
                cls = ($urandom_range(99) < 4) ? CLASS_BAD : CLASS_W'($urandom_range(2));
                send_word(op, cls, pick_pages());
                if (!(op == OP_ENQUEUE && cls == CLASS_BAD))
                    sent++;
            end
        end
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 18;
        recv_idle_pct = 54;
        test_empty_dequeue();
        test_page_extremes();
        test_class_order();
        test_full_store();
        test_backpressure();

        test_random_traffic(400, 18, 54);
        test_random_traffic(400, 54, 18);
        test_random_traffic(400, 0, 0);

        // Let any stray result word show itself before the verdict.
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0)
            report_failure($sformatf("%0d result words never arrived",
                                     expected_results.size()));

        if (failure_count == 0)
            $display("** class_priority_job_queue: PASSED **");
        else
            $display("** class_priority_job_queue: FAILED **");
        $finish;
    end

endmodule
